FILE: rtl/histogram_equalization_macros.svh
// Assertion macros shared by the histogram equalization checker.
// No dependencies.
`ifndef HISTOGRAM_EQUALIZATION_MACROS_SVH
`define HISTOGRAM_EQUALIZATION_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define HEQ_ASSERT_RST(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");

// Clocked assertion that also holds during reset.
`define HEQ_ASSERT(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("%m failed");

`endif

FILE: rtl/heq_pkg.sv
// Types, constants and helpers for the histogram equalization block.
// No dependencies.
package heq_pkg;

  localparam int MAX_PIXELS_DEF = 4194304;

  typedef struct packed {
    logic       mode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic [7:0] eq_red;
    logic [7:0] eq_green;
    logic [7:0] eq_blue;
  } out_t;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_MAP, ST_LRD, ST_LWR, ST_BSTART, ST_BRD, ST_BACC, ST_BSTEP
  } state_e;

  typedef struct packed {
    logic clr_wr;
    logic cap;
    logic bin_rd;
    logic bin_inc;
    logic bld_start;
    logic bld_rd;
    logic bld_acc;
    logic bld_step;
    logic bld_wr;
    logic map_out;
  } cmd_t;

  typedef struct packed {
    logic last_idx;
    logic step_more;
    logic room;
    logic frame_end;
    logic out_busy;
  } sts_t;

  function automatic logic [7:0] gray_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [15:0] sum;
    sum = 16'(16'd54 * r) + 16'(16'd182 * g) + 16'(16'd18 * b);
    return sum[15:8];
  endfunction

endpackage

FILE: rtl/heq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module heq_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

FILE: rtl/heq_ctrl.sv
// Controller state machine of the histogram equalization block.
// Depends on heq_pkg.
module heq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_mode_i,
  output logic           in_ready_o,
  input  heq_pkg::sts_t  sts_i,
  output heq_pkg::cmd_t  cmd_o
);
  import heq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.last_idx) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = !sts_i.out_busy;
        if (in_valid_i && in_ready_o) begin
          cmd_o.cap = 1'b1;
          state_d   = in_mode_i ? ST_MAP : ST_LRD;
        end
      end
      ST_MAP: begin
        cmd_o.map_out = 1'b1;
        state_d       = ST_IDLE;
      end
      ST_LRD: begin
        if (sts_i.room) begin
          cmd_o.bin_rd = 1'b1;
          state_d      = ST_LWR;
        end else begin
          state_d = sts_i.frame_end ? ST_BSTART : ST_IDLE;
        end
      end
      ST_LWR: begin
        cmd_o.bin_inc = 1'b1;
        state_d       = sts_i.frame_end ? ST_BSTART : ST_IDLE;
      end
      ST_BSTART: begin
        cmd_o.bld_start = 1'b1;
        state_d         = ST_BRD;
      end
      ST_BRD: begin
        cmd_o.bld_rd = 1'b1;
        state_d      = ST_BACC;
      end
      ST_BACC: begin
        cmd_o.bld_acc = 1'b1;
        state_d       = ST_BSTEP;
      end
      ST_BSTEP: begin
        if (sts_i.step_more) begin
          cmd_o.bld_step = 1'b1;
        end else begin
          cmd_o.bld_wr = 1'b1;
          state_d      = sts_i.last_idx ? ST_IDLE : ST_BRD;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end
endmodule

FILE: rtl/heq_dp.sv
// Datapath: histogram and table memories, counters and the table builder.
// Depends on heq_pkg and heq_ram.
module heq_dp #(
  parameter int MaxPixels = heq_pkg::MAX_PIXELS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  heq_pkg::in_t   in_req_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output heq_pkg::out_t  out_req_o,
  input  heq_pkg::cmd_t  cmd_i,
  output heq_pkg::sts_t  sts_o
);
  import heq_pkg::*;

  localparam int CW = $clog2(MaxPixels + 1);
  localparam int AW = CW + 8;

  logic [7:0]    gray_q, idx_q, q_q;
  logic          frame_end_q, flat_q, out_valid_q;
  logic [CW-1:0] total_q, c0_q, cum_q, span_q;
  logic [AW-1:0] acc_q, num;
  logic [CW-1:0] dcum;
  out_t          out_q;

  logic          bin_we;
  logic [7:0]    bin_waddr, bin_raddr;
  logic [CW-1:0] bin_wdata, bin_rdata;
  logic          map_we;
  logic [7:0]    map_wdata, rd_r, rd_g, rd_b;

  assign bin_we    = cmd_i.clr_wr | cmd_i.bin_inc | cmd_i.bld_acc;
  assign bin_waddr = cmd_i.bin_inc ? gray_q : idx_q;
  assign bin_wdata = cmd_i.bin_inc ? bin_rdata + CW'(1) : '0;
  assign bin_raddr = cmd_i.bld_rd ? idx_q : gray_q;
  assign map_we    = cmd_i.clr_wr | cmd_i.bld_wr;
  assign map_wdata = cmd_i.clr_wr ? 8'd0 : q_q;

  heq_ram #(.Width(CW), .Depth(256)) u_bin_ram (
    .clk_i, .we_i(bin_we), .waddr_i(bin_waddr), .wdata_i(bin_wdata),
    .raddr_i(bin_raddr), .rdata_o(bin_rdata)
  );
  heq_ram #(.Width(8), .Depth(256)) u_map_r (
    .clk_i, .we_i(map_we), .waddr_i(idx_q), .wdata_i(map_wdata),
    .raddr_i(in_req_i.red), .rdata_o(rd_r)
  );
  heq_ram #(.Width(8), .Depth(256)) u_map_g (
    .clk_i, .we_i(map_we), .waddr_i(idx_q), .wdata_i(map_wdata),
    .raddr_i(in_req_i.green), .rdata_o(rd_g)
  );
  heq_ram #(.Width(8), .Depth(256)) u_map_b (
    .clk_i, .we_i(map_we), .waddr_i(idx_q), .wdata_i(map_wdata),
    .raddr_i(in_req_i.blue), .rdata_o(rd_b)
  );

  assign dcum = cum_q - c0_q;
  assign num  = (AW'(dcum) << 8) - AW'(dcum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      total_q     <= '0;
      c0_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr || (cmd_i.bld_wr && idx_q != 8'hFF)) begin
        idx_q <= idx_q + 8'd1;
      end else if (cmd_i.bld_start) begin
        idx_q <= '0;
      end
      if (cmd_i.bin_inc) begin
        total_q <= total_q + CW'(1);
        if (gray_q == 8'd0) begin
          c0_q <= c0_q + CW'(1);
        end
      end else if (cmd_i.bld_wr && idx_q == 8'hFF) begin
        total_q <= '0;
        c0_q    <= '0;
      end
      if (cmd_i.map_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      gray_q      <= gray_of(in_req_i.red, in_req_i.green, in_req_i.blue);
      frame_end_q <= in_req_i.frame_end;
    end
    if (cmd_i.bld_start) begin
      flat_q <= (total_q <= c0_q);
      span_q <= total_q - c0_q;
      acc_q  <= AW'(total_q - c0_q);
      cum_q  <= '0;
      q_q    <= '0;
    end else if (cmd_i.bld_acc) begin
      cum_q <= cum_q + bin_rdata;
    end else if (cmd_i.bld_step) begin
      q_q   <= q_q + 8'd1;
      acc_q <= acc_q + AW'(span_q);
    end
    if (cmd_i.map_out) begin
      out_q <= '{eq_red: rd_r, eq_green: rd_g, eq_blue: rd_b};
    end
  end

  assign sts_o.last_idx  = (idx_q == 8'hFF);
  assign sts_o.step_more = !flat_q && (q_q != 8'hFF) && (acc_q <= num);
  assign sts_o.room      = (total_q < CW'(MaxPixels));
  assign sts_o.frame_end = frame_end_q;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_req_o       = out_q;
endmodule

FILE: rtl/histogram_equalization.sv
// Map request: the result is registered in the map state, and no new request is taken
// until the block is back in idle. Load request: a bin read, then an increment that is
// skipped once the frame holds MaxPixels pixels. A frame end adds a table build: a start
// state, then per bin a read, accumulate and step state, plus one step per output level,
// paced by the single histogram read port. After reset a pass over all 256 entries clears
// histogram and table before requests are taken. Reset is asynchronous, active low.
module histogram_equalization #(
  parameter int MaxPixels = heq_pkg::MAX_PIXELS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  heq_pkg::in_t  in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output heq_pkg::out_t out_req_o
);
  import heq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  heq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_mode_i(in_req_i.mode), .in_ready_o,
    .sts_i(sts), .cmd_o(cmd)
  );

  heq_dp #(.MaxPixels(MaxPixels)) u_dp (
    .clk_i, .rst_ni, .in_req_i, .out_ready_i, .out_valid_o, .out_req_o,
    .cmd_i(cmd), .sts_o(sts)
  );
endmodule

FILE: rtl/heq_checker.sv
// Port-level checks for the histogram equalization block, bound to its top.
// Depends on heq_pkg and histogram_equalization_macros.svh.
`include "histogram_equalization_macros.svh"
module heq_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input heq_pkg::in_t  in_req_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input heq_pkg::out_t out_req_o
);
  `HEQ_ASSERT_RST(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_req_o))
  `HEQ_ASSERT(a_no_ready_when_full, clk_i, in_ready_o |-> !(out_valid_o && !out_ready_i))
  `HEQ_ASSERT_RST(a_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o)
  `HEQ_ASSERT_RST(a_out_from_map, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && in_req_i.mode, 2))
endmodule

bind histogram_equalization heq_checker u_heq_checker (.*);

FILE: dv/tb_histogram_equalization.sv
// Self-checking testbench for the histogram equalization block: loads frames of pixels,
// maps pixels through the equalization table and compares each result with a local model.
// Depends on heq_pkg and the histogram_equalization RTL.
`timescale 1ns / 100ps

module tb_histogram_equalization;
  import heq_pkg::*;

  localparam int unsigned MaxPix = 4194304;
  localparam int unsigned WatchLimit = 40000;
  localparam logic ModeLoad = 1'b0;
  localparam logic ModeMap = 1'b1;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_req;
  logic out_valid;
  logic out_ready;
  out_t out_req;

  int unsigned hist_bins[256];
  logic [7:0]  eq_lut[256];
  int unsigned frame_pixels;
  logic        frame_done;
  out_t        pending_results[$];
  int unsigned error_count;
  int unsigned idle_cycles;
  int unsigned map_count;
  int unsigned frame_count;
  bit          quiet_in;
  bit          quiet_out;

  typedef struct {
    in_t  req;
    bit   has_exp;
    out_t exp;
  } row_t;

  histogram_equalization i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_req_o  (out_req)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] luma(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned s;
    s = 54 * r + 182 * g + 18 * b;
    return 8'(s >> 8);
  endfunction

  function automatic void rebuild_lut();
    longint unsigned c0, n, cum, q;
    c0 = hist_bins[0];
    n = frame_pixels;
    cum = 0;
    for (int v = 0; v < 256; v++) begin
      cum += hist_bins[v];
      if (n <= c0) q = 0;
      else q = (cum > c0) ? (255 * (cum - c0)) / (n - c0) : 0;
      if (q > 255) q = 255;
      eq_lut[v] = 8'(q);
    end
  endfunction

  function automatic void equalize_predict(in_t r);
    out_t o;
    if (r.mode == ModeMap) begin
      o.eq_red = eq_lut[r.red];
      o.eq_green = eq_lut[r.green];
      o.eq_blue = eq_lut[r.blue];
      pending_results.push_back(o);
      map_count++;
      return;
    end
    if (frame_done) begin
      foreach (hist_bins[i]) hist_bins[i] = 0;
      frame_pixels = 0;
      frame_done = 1'b0;
    end
    if (frame_pixels < MaxPix) begin
      hist_bins[luma(r.red, r.green, r.blue)]++;
      frame_pixels++;
    end
    if (r.frame_end) begin
      rebuild_lut();
      frame_done = 1'b1;
      frame_count++;
    end
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Output side: random stalls, checks each accepted result against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_req, 0);
      end else begin
        out_t e;
        e = pending_results.pop_front();
        if (out_req.eq_red !== e.eq_red) report_mismatch("eq_red", out_req.eq_red, e.eq_red);
        if (out_req.eq_green !== e.eq_green)
          report_mismatch("eq_green", out_req.eq_green, e.eq_green);
        if (out_req.eq_blue !== e.eq_blue)
          report_mismatch("eq_blue", out_req.eq_blue, e.eq_blue);
      end
    end
    out_ready <= quiet_out ? 1'b1 : ($urandom_range(99) >= 15);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("timeout after %0d cycles without progress", idle_cycles);
      $display("histogram_equalization regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(in_t r);
    while (!quiet_in && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    equalize_predict(r);
  endtask

  function automatic in_t make_req(logic m, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                   logic fe);
    in_t q;
    q.mode = m;
    q.red = r;
    q.green = g;
    q.blue = b;
    q.frame_end = fe;
    return q;
  endfunction

  function automatic in_t rand_pixel(logic m, logic fe);
    return make_req(m, 8'($urandom), 8'($urandom), 8'($urandom), fe);
  endfunction

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  row_t directed[$];

  initial begin
    out_t z;
    out_t full;
    z = '0;
    full = '1;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    out_ready = 1'b0;
    error_count = 0;
    idle_cycles = 0;
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    foreach (hist_bins[i]) hist_bins[i] = 0;
    foreach (eq_lut[i]) eq_lut[i] = '0;
    frame_pixels = 0;
    frame_done = 1'b1;

    // After reset the table is all zero; a frame of black and white pixels maps black
    // to 0 and white to 255; a frame of black pixels only is flat and maps everything to 0.
    directed = '{
      '{make_req(ModeMap, 8'd255, 8'd0, 8'd128, 1'b1), 1'b1, z},
      '{make_req(ModeLoad, 8'd0, 8'd0, 8'd0, 1'b0), 1'b0, z},
      '{make_req(ModeLoad, 8'd255, 8'd255, 8'd255, 1'b1), 1'b0, z},
      '{make_req(ModeMap, 8'd0, 8'd0, 8'd0, 1'b0), 1'b1, z},
      '{make_req(ModeMap, 8'd255, 8'd255, 8'd255, 1'b0), 1'b1, full},
      '{make_req(ModeLoad, 8'd255, 8'd0, 8'd0, 1'b0), 1'b0, z},
      '{make_req(ModeMap, 8'd254, 8'd1, 8'd200, 1'b0), 1'b0, z},
      '{make_req(ModeLoad, 8'd0, 8'd255, 8'd0, 1'b0), 1'b0, z},
      '{make_req(ModeLoad, 8'd0, 8'd0, 8'd255, 1'b0), 1'b0, z},
      '{make_req(ModeLoad, 8'd85, 8'd170, 8'd15, 1'b1), 1'b0, z},
      '{make_req(ModeMap, 8'd0, 8'd255, 8'd85, 1'b0), 1'b0, z},
      '{make_req(ModeMap, 8'd170, 8'd15, 8'd240, 1'b0), 1'b0, z},
      '{make_req(ModeLoad, 8'd0, 8'd0, 8'd0, 1'b0), 1'b0, z},
      '{make_req(ModeLoad, 8'd1, 8'd0, 8'd1, 1'b1), 1'b0, z},
      '{make_req(ModeMap, 8'd255, 8'd128, 8'd0, 1'b0), 1'b1, z},
      '{make_req(ModeLoad, 8'd100, 8'd100, 8'd100, 1'b1), 1'b0, z},
      '{make_req(ModeMap, 8'd100, 8'd99, 8'd255, 1'b0), 1'b0, z}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].has_exp) begin
        out_t pred;
        equalize_predict(directed[i].req);
        pred = pending_results.pop_back();
        map_count--;
        if (pred !== directed[i].exp)
          report_mismatch($sformatf("table row %0d", i), pred, directed[i].exp);
      end
      send_request(directed[i].req);
    end

    // Random frames of varied sizes, each followed by a burst of maps; some frames
    // gather on a narrow gray range, and a few requests are stray noise.
    while (map_count < 500 || frame_count < 27) begin
      int unsigned npix;
      int unsigned base;
      int unsigned span;
      npix = ($urandom_range(9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 24);
      base = $urandom_range(255);
      span = $urandom_range(3) == 0 ? 255 : $urandom_range(1, 40);
      quiet_in = (frame_count >= 10 && frame_count < 14);
      quiet_out = quiet_in;
      for (int p = 0; p < npix; p++) begin
        in_t q;
        if (span == 255) begin
          q = rand_pixel(ModeLoad, p == npix - 1);
        end else begin
          logic [7:0] v;
          v = 8'((base + $urandom_range(span)) % 256);
          q = make_req(ModeLoad, v, v, v, p == npix - 1);
        end
        send_request(q);
        if ($urandom_range(19) == 0) send_request(rand_pixel(ModeMap, 1'($urandom)));
      end
      repeat ($urandom_range(4, 30)) send_request(rand_pixel(ModeMap, 1'($urandom)));
      if (frame_count == 5) begin
        drain_results();
        repeat (1100) @(posedge clk);
      end
    end

    drain_results();
    repeat (50) @(posedge clk);
    $display("covered %0d frames and %0d map requests, flat frames and stalls on both sides",
             frame_count, map_count);
    if (error_count == 0) begin
      $display("histogram_equalization regression: pass");
    end else begin
      $display("histogram_equalization regression: fail");
    end
    $finish;
  end

endmodule
